>>> hdl/nps_pkg.sv
// nps_pkg: shared constants and types for the nearest point search table.
// No dependencies; used by every module in hdl/.
package nps_pkg;

   localparam int NODE_ID_W      = 8;
   localparam int COORD_W        = 24;
   localparam int MAX_NODES_DEF  = 256;
   localparam int COORD_BITS_DEF = 24;

   typedef enum logic [0:0] {
      CMD_REGISTER = 1'b0,
      CMD_QUERY    = 1'b1
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic wr_en;     // write req_ item into table
      logic start;     // latch query point, clear best
      logic issue;     // push scan address into pipeline
      logic load_rsp;  // copy best into result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_empty;  // no table entry in flight
   } dp_status_type;

endpackage

>>> hdl/nps_ctrl.sv
// nps_ctrl: sequencer for register and query items, scan counter, result valid.
// Depends on nps_pkg.
module nps_ctrl #(
   parameter int MAX_NODES = nps_pkg::MAX_NODES_DEF,
   localparam int IDX_W = $clog2(MAX_NODES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  nps_pkg::dp_status_type status,
   output nps_pkg::ctrl_cmd_type cmd,
   output logic [IDX_W-1:0]      scan_addr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             last_addr;
   logic             can_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_addr = (addr_ff == IDX_W'(MAX_NODES - 1));
   assign can_load  = status.pipe_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == nps_pkg::CMD_QUERY) begin
               cmd.start = 1'b1;
               addr_in   = '0;
               state_in  = ST_SCAN;
            end else if (accept) begin
               cmd.wr_en = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            addr_in   = addr_ff + IDX_W'(1);
            if (last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = addr_ff;

endmodule

>>> hdl/nps_dp.sv
// nps_dp: position memory, valid bits, distance pipeline and best tracker.
// Depends on nps_pkg.
module nps_dp #(
   parameter int MAX_NODES  = nps_pkg::MAX_NODES_DEF,
   parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_NODES)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nps_pkg::ctrl_cmd_type                cmd,
   input  logic [IDX_W-1:0]                     scan_addr,
   input  logic [nps_pkg::NODE_ID_W-1:0]        req_node_id,
   input  logic signed [nps_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [nps_pkg::COORD_W-1:0]   req_coord_y,
   output nps_pkg::dp_status_type               status,
   output logic [nps_pkg::NODE_ID_W-1:0]        rsp_nearest_id,
   output logic                                 rsp_found
);

   localparam int CB   = COORD_BITS;
   localparam int SQW  = 2 * CB;
   localparam int DSTW = SQW + 1;

   // table
   logic [2*CB-1:0]       pos_mem [MAX_NODES];
   logic [MAX_NODES-1:0]  node_valid_ff;

   logic signed [CB-1:0]  wr_x, wr_y;
   logic [IDX_W-1:0]      wr_idx;
   logic                  wr_ok;

   // query point
   logic signed [CB-1:0]  qx_ff, qy_ff;

   // stage 1: table read
   logic                  s1_v_ff;
   logic [IDX_W-1:0]      s1_id_ff;
   logic [2*CB-1:0]       s1_pos_ff;
   logic signed [CB-1:0]  s1_px, s1_py;
   // stage 2: abs differences
   logic signed [CB:0]    diff_x, diff_y;
   logic [CB-1:0]         dx_in, dy_in, dx_ff, dy_ff;
   logic                  s2_v_ff;
   logic [IDX_W-1:0]      s2_id_ff;
   // stage 3: squares
   logic [SQW-1:0]        sqx_ff, sqy_ff;
   logic                  s3_v_ff;
   logic [IDX_W-1:0]      s3_id_ff;
   // stage 4: sum
   logic [DSTW-1:0]       dist_ff;
   logic                  s4_v_ff;
   logic [IDX_W-1:0]      s4_id_ff;
   // best so far
   logic [DSTW-1:0]       best_d_ff;
   logic [IDX_W-1:0]      best_id_ff;
   logic                  have_ff;
   logic                  take;
   // result register
   logic [nps_pkg::NODE_ID_W-1:0] rsp_id_ff;
   logic                          rsp_found_ff;

   // coordinates: low COORD_BITS bits, sign extended
   assign wr_x   = CB'(req_coord_x);
   assign wr_y   = CB'(req_coord_y);
   assign wr_idx = IDX_W'(req_node_id);
   assign wr_ok  = 32'(req_node_id) < MAX_NODES;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         pos_mem[wr_idx] <= {wr_x, wr_y};
      end
      s1_pos_ff <= pos_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_valid_ff <= '0;
      end else if (cmd.wr_en && wr_ok) begin
         node_valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         qx_ff <= wr_x;
         qy_ff <= wr_y;
      end
   end

   assign s1_px  = s1_pos_ff[2*CB-1:CB];
   assign s1_py  = s1_pos_ff[CB-1:0];
   assign diff_x = (CB+1)'(s1_px) - (CB+1)'(qx_ff);
   assign diff_y = (CB+1)'(s1_py) - (CB+1)'(qy_ff);
   // |diff| < 2**CB, so it fits in CB bits
   assign dx_in  = diff_x[CB] ? CB'(-diff_x) : CB'(diff_x);
   assign dy_in  = diff_y[CB] ? CB'(-diff_y) : CB'(diff_y);

   always_ff @(posedge clock) begin
      s1_id_ff <= scan_addr;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      s2_id_ff <= s1_id_ff;
      sqx_ff   <= SQW'(dx_ff) * SQW'(dx_ff);
      sqy_ff   <= SQW'(dy_ff) * SQW'(dy_ff);
      s3_id_ff <= s2_id_ff;
      dist_ff  <= DSTW'(sqx_ff) + DSTW'(sqy_ff);
      s4_id_ff <= s3_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.issue && node_valid_ff[scan_addr];
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // strict less-than: the lower id keeps a tie
   assign take = s4_v_ff && (!have_ff || dist_ff < best_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.start) begin
         have_ff <= 1'b0;
      end else if (take) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff  <= dist_ff;
         best_id_ff <= s4_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_id_ff    <= have_ff ? nps_pkg::NODE_ID_W'(best_id_ff) : '0;
         rsp_found_ff <= have_ff;
      end
   end

   assign status.pipe_empty = !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff);
   assign rsp_nearest_id    = rsp_id_ff;
   assign rsp_found         = rsp_found_ff;

endmodule

>>> hdl/nearest_point_search_table_top.sv
// Query: the controller scans every id, then waits while valid entries at the top ids are still
// in the distance pipeline before raising rsp_valid, also held off by any rsp_ready stall.
// The single distance unit walks the table one id per cycle; no new item is accepted until
// a query's result is loaded. A register item is accepted while idle and gives no result.
// Synchronous active-high reset clears the valid bits, controller and pipeline;
// table coordinates are undefined until written. Depends on nps_pkg, nps_ctrl, nps_dp.
module nearest_point_search_table_top #(
   parameter int MAX_NODES  = nps_pkg::MAX_NODES_DEF,
   parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request item
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [nps_pkg::NODE_ID_W-1:0]      req_node_id,
   input  logic signed [nps_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [nps_pkg::COORD_W-1:0] req_coord_y,
   // result item
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nps_pkg::NODE_ID_W-1:0]      rsp_nearest_id,
   output logic                               rsp_found
);

   localparam int IDX_W = $clog2(MAX_NODES);

   nps_pkg::ctrl_cmd_type  cmd;
   nps_pkg::dp_status_type status;
   logic [IDX_W-1:0]       scan_addr;

   // Controller: idle accepts both item kinds; a query walks ids 0..MAX_NODES-1,
   // waits for the pipeline to drain, then loads the result register once any
   // earlier result has been taken.
   nps_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd),
      .scan_addr   (scan_addr)
   );

   // Datapath: table read, |dx|/|dy|, squares, sum, strict-less compare.
   nps_dp #(
      .MAX_NODES  (MAX_NODES),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .scan_addr      (scan_addr),
      .req_node_id    (req_node_id),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .status         (status),
      .rsp_nearest_id (rsp_nearest_id),
      .rsp_found      (rsp_found)
   );

endmodule

>>> hdl/nps_check.sv
// nps_check: port-level assertions for nearest_point_search_table_top, bound below.
// Depends on nps_pkg.
module nps_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               req_command,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [nps_pkg::NODE_ID_W-1:0]      rsp_nearest_id,
   input logic                               rsp_found
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nearest_id) && $stable(rsp_found))
      else $error("result item changed while stalled");

   // empty table reports id zero
   a_empty_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_nearest_id == '0)
      else $error("not found but nonzero id");

   // a query blocks further items while it scans
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == nps_pkg::CMD_QUERY |=> !req_ready ##1 !req_ready)
      else $error("item accepted during scan");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind nearest_point_search_table_top nps_check u_nps_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_nearest_id (rsp_nearest_id),
   .rsp_found      (rsp_found)
);
